[design/dpc_pkg.sv]
// Package with the shared types and constants of the disk port controller.
`default_nettype none
package dpc_pkg;

  localparam int SectorBytes     = 128;
  localparam int SectorsPerTrack = 64;
  localparam int PosW            = 22;
  localparam int SecShift        = $clog2(SectorBytes);
  localparam int TrkShift        = $clog2(SectorsPerTrack);
  localparam int PhaseW          = 4;

  localparam logic [PhaseW-1:0] PHASE_FIRST = 4'd1;
  localparam logic [PhaseW-1:0] PHASE_UNIT  = 4'd1;
  localparam logic [PhaseW-1:0] PHASE_TRACK = 4'd2;
  localparam logic [PhaseW-1:0] PHASE_SECT  = 4'd3;
  localparam logic [PhaseW-1:0] PHASE_FMT0  = 4'd4;
  localparam logic [PhaseW-1:0] PHASE_SEEK  = 4'd7;
  localparam logic [PhaseW-1:0] PHASE_MAX   = 4'd8;
  localparam logic [PhaseW-1:0] PHASE_ZERO  = 4'd0;

  // Access kinds.
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Port numbers.
  localparam logic [7:0] PORT_01   = 8'h01;
  localparam logic [7:0] PORT_02   = 8'h02;
  localparam logic [7:0] PORT_2A   = 8'h2a;
  localparam logic [7:0] PORT_2B   = 8'h2b;
  localparam logic [7:0] PORT_AA   = 8'haa;
  localparam logic [7:0] PORT_AB   = 8'hab;
  localparam logic [7:0] PORT_DATA = 8'hae;
  localparam logic [7:0] PORT_CTRL = 8'haf;

  // Function codes.
  localparam logic [7:0] FN_DISK   = 8'd0;
  localparam logic [7:0] FN_DISK2  = 8'd2;
  localparam logic [7:0] FN_SSTAT  = 8'd4;
  localparam logic [7:0] FN_BUSY   = 8'd8;
  localparam logic [7:0] FN_FORMAT = 8'd10;
  localparam logic [7:0] FN_CLOCK  = 8'd11;

  // Constant bytes.
  localparam logic [7:0] CODE_IDLE  = 8'hcb;
  localparam logic [7:0] ST_READY   = 8'h4a;
  localparam logic [7:0] ST_PEND    = 8'h48;
  localparam logic [7:0] ST_DONE    = 8'h50;
  localparam logic [7:0] ID_2A      = 8'h37;
  localparam logic [7:0] ID_AA      = 8'h38;
  localparam logic [7:0] ID_ONE     = 8'h01;
  localparam logic [7:0] SS_BASE    = 8'h02;
  localparam logic [7:0] SS_FLOPPY  = 8'h80;

  typedef struct packed {
    logic [15:0] clock_ms;
    logic [7:0]  disk_byte;
    logic [7:0]  write_data;
    logic [7:0]  port;
    logic        cmd;
  } item_t;

  typedef struct packed {
    logic            bad_port;
    logic            unit_select;
    logic            format_req;
    logic [PosW-1:0] seek_pos;
    logic            seek_req;
    logic            disk_write_req;
    logic            disk_read_req;
    logic [7:0]      read_data;
  } result_t;

endpackage
`default_nettype wire

[design/disk_port_controller.sv]
// Top level of the disk port controller.
//
//   channel  direction  payload
//   in_      slave      tuser: cmd; tdata: port, write_data, disk_byte, clock_ms
//   out_     master     tdata: read_data, request flags, seek_pos, unit, bad_port
//   cfg_     slave      data: floppy_present
//
// One access per cycle sustained while results are taken; each access passes
// through the input register, then through the decode into the result register.
// Reset clears all control state and the controller registers.
// A stalled result holds the access in the input register, which frees again
// in the same cycle the result transfer completes.
`default_nettype none
module disk_port_controller import dpc_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [39:0] in_tdata,   // port, write_data, disk_byte, clock_ms
  input  wire  [0:0]  in_tuser,   // cmd
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [39:0] out_tdata,  // read_data, disk_read_req, disk_write_req, seek_req,
                                  // seek_pos, format_req, unit_select, bad_port, zero pad
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [0:0]  cfg_data    // floppy_present
);

  item_t   in_item, item;
  result_t res, out_res;
  logic    item_valid, space, fire;
  logic    floppy_r;

  assign in_item   = {in_tdata, in_tuser[0]};
  assign fire      = item_valid && space;
  assign cfg_ready = 1'b1;
  assign out_tdata = {{(40 - $bits(result_t)){1'b0}}, out_res};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floppy_r <= 1'b0;
    end else if (cfg_valid) begin
      floppy_r <= cfg_data[0];
    end
  end

  dpc_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .take       (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  dpc_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .fire           (fire),
    .floppy_present (floppy_r),
    .item           (item),
    .res            (res)
  );

  dpc_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .res       (res),
    .space     (space),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

endmodule
`default_nettype wire

[design/dpc_in_stage.sv]
// Input register stage of the disk port controller.
`default_nettype none
module dpc_in_stage import dpc_pkg::*; (
  input  wire   clk,
  input  wire   rst_n,
  input  wire   in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  wire   take,
  output logic  item_valid,
  output item_t item
);

  logic  valid_r, valid_nxt;
  item_t item_r;

  assign in_ready   = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule
`default_nettype wire

[design/dpc_core.sv]
// Port decode and controller state update for one access.
`default_nettype none
module dpc_core import dpc_pkg::*; (
  input  wire     clk,
  input  wire     rst_n,
  input  wire     fire,
  input  wire     floppy_present,
  input  item_t   item,
  output result_t res
);

  logic [7:0]        pending_r, pending_nxt;
  logic [7:0]        func_r, func_nxt;
  logic [PhaseW-1:0] phase_r, phase_nxt;
  logic              unit_r, unit_nxt;
  logic [7:0]        track_r, track_nxt;
  logic [7:0]        sector_r, sector_nxt;
  logic [7:0]        status_r, status_nxt;
  logic [7:0]        sstat_r, sstat_nxt;
  logic              half_r, half_nxt;

  logic [PhaseW-1:0] phase_adv;
  logic [14:0]       blk;
  logic [14:0]       blk_m1;
  logic              any_req;

  assign phase_adv = (phase_r < PHASE_MAX) ? phase_r + PHASE_FIRST : PHASE_MAX;
  assign blk    = {1'b0, track_r, {TrkShift{1'b0}}} + {7'b0, sector_r};
  assign blk_m1 = blk - 15'd1;

  always_comb begin
    pending_nxt = pending_r;
    func_nxt    = func_r;
    phase_nxt   = phase_r;
    unit_nxt    = unit_r;
    track_nxt   = track_r;
    sector_nxt  = sector_r;
    status_nxt  = status_r;
    sstat_nxt   = sstat_r;
    half_nxt    = half_r;
    res         = '0;

    if (item.cmd == CMD_READ) begin
      unique case (item.port) inside
        PORT_01, PORT_02: res.read_data = 8'h00;
        PORT_2A:          res.read_data = ID_2A;
        PORT_2B, PORT_AB: res.read_data = ID_ONE;
        PORT_AA:          res.read_data = ID_AA;
        PORT_DATA: begin
          if (func_r == FN_DISK) begin
            res.read_data     = item.disk_byte;
            res.disk_read_req = 1'b1;
          end else if (func_r == FN_CLOCK) begin
            res.read_data = half_r ? item.clock_ms[7:0] : item.clock_ms[15:8];
            half_nxt      = !half_r;
          end else if (func_r == FN_SSTAT) begin
            res.read_data = sstat_r;
          end
        end
        PORT_CTRL: begin
          res.read_data = status_r;
          if (func_r == FN_DISK || func_r == FN_DISK2 || func_r == FN_CLOCK) begin
            status_nxt = ST_DONE;
          end
        end
        default: res.bad_port = 1'b1;
      endcase
    end else begin
      unique case (item.port) inside
        PORT_02, PORT_2B, PORT_AB: ;
        PORT_DATA: begin
          if (func_r == FN_DISK || func_r == FN_DISK2 || func_r == FN_FORMAT) begin
            phase_nxt = phase_adv;
            if (phase_r == PHASE_UNIT) begin
              unit_nxt = item.write_data[0];
            end else if (phase_r == PHASE_TRACK) begin
              track_nxt = item.write_data;
            end else if (phase_r == PHASE_SECT) begin
              sector_nxt = item.write_data;
            end else if (func_r == FN_FORMAT) begin
              if (phase_r != PHASE_FMT0) begin
                res.format_req = 1'b1;
              end
            end else if (phase_r == PHASE_SEEK) begin
              // An all-zero track and sector would seek before the start of the disk.
              if (blk != 15'd0) begin
                res.seek_req = 1'b1;
                res.seek_pos = {blk_m1, {SecShift{1'b0}}};
              end
            end else if (phase_r >= PHASE_MAX || phase_r == PHASE_ZERO) begin
              res.disk_write_req = 1'b1;
              status_nxt         = ST_DONE;
            end
          end
        end
        PORT_CTRL: begin
          if (~item.write_data == pending_r) begin
            func_nxt    = pending_r;
            pending_nxt = CODE_IDLE;
            phase_nxt   = PHASE_FIRST;
            case (pending_r) inside
              FN_DISK, FN_DISK2, FN_FORMAT, FN_CLOCK: begin
                status_nxt = ST_READY;
                half_nxt   = 1'b1;
              end
              FN_SSTAT: begin
                status_nxt = ST_READY;
                sstat_nxt  = floppy_present ? (SS_BASE | SS_FLOPPY) : SS_BASE;
              end
              FN_BUSY: status_nxt = ST_DONE;
              default: sstat_nxt = SS_BASE;
            endcase
          end else begin
            pending_nxt = item.write_data;
            status_nxt  = ST_PEND;
          end
        end
        default: res.bad_port = 1'b1;
      endcase
    end

    any_req = res.disk_read_req | res.disk_write_req | res.seek_req | res.format_req;
    res.unit_select = any_req ? unit_nxt : 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= CODE_IDLE;
      func_r    <= FN_DISK;
      phase_r   <= PHASE_FIRST;
      unit_r    <= 1'b0;
      track_r   <= 8'h00;
      sector_r  <= 8'h00;
      status_r  <= 8'h00;
      sstat_r   <= 8'h00;
      half_r    <= 1'b1;
    end else if (fire) begin
      pending_r <= pending_nxt;
      func_r    <= func_nxt;
      phase_r   <= phase_nxt;
      unit_r    <= unit_nxt;
      track_r   <= track_nxt;
      sector_r  <= sector_nxt;
      status_r  <= status_nxt;
      sstat_r   <= sstat_nxt;
      half_r    <= half_nxt;
    end
  end

endmodule
`default_nettype wire

[design/dpc_out_stage.sv]
// Result register stage of the disk port controller.
`default_nettype none
module dpc_out_stage import dpc_pkg::*; (
  input  wire     clk,
  input  wire     rst_n,
  input  wire     fire,
  input  result_t res,
  output logic    space,
  output logic    out_valid,
  input  wire     out_ready,
  output result_t out_res
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign space     = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (fire) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

endmodule
`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the disk port controller with a stream driver and monitor.
module tb_top;
  import dpc_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  wire         in_tready;
  logic [39:0] in_tdata = '0;   // port, write_data, disk_byte, clock_ms
  logic [0:0]  in_tuser = '0;   // cmd
  wire         out_tvalid;
  logic        out_tready = 1'b0;
  wire  [39:0] out_tdata;       // read_data, disk_read_req, disk_write_req, seek_req,
                                // seek_pos, format_req, unit_select, bad_port, zero pad
  logic        cfg_valid = 1'b0;
  wire         cfg_ready;
  logic [0:0]  cfg_data = '0;   // floppy_present

  disk_port_controller dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  // Shadow copy of the controller state.
  logic [7:0]  pend_code = CODE_IDLE;
  logic [7:0]  act_fn = FN_DISK;
  logic [3:0]  phase = PHASE_FIRST;
  logic        unit_b = 1'b0;
  logic [7:0]  trk = 8'h00;
  logic [7:0]  sec = 8'h00;
  logic [7:0]  stat = 8'h00;
  logic [7:0]  sstat = 8'h00;
  logic        clk_half = 1'b1;
  logic        floppy_cfg = 1'b0;

  item_t       access_q[$];
  result_t     port_result_q[$];
  item_t       drv_item;
  item_t       seen_item;
  result_t     want;
  result_t     got;
  int          pushed_count = 0;
  int          accepted_count = 0;
  int          res_count = 0;
  int          err_count = 0;
  logic        in_fire = 1'b0;
  int          in_gap = 0;
  int          in_calm = 0;
  int          out_stall = 0;
  int          out_calm = 0;
  int          press_left = 0;
  logic        pressed = 1'b0;

  function automatic result_t predict_access(item_t a);
    result_t r;
    logic [3:0] p;
    int base;
    r = '0;
    if (a.cmd == CMD_READ) begin
      case (a.port) inside
        PORT_01, PORT_02: r.read_data = 8'h00;
        PORT_2A: r.read_data = ID_2A;
        PORT_2B: r.read_data = ID_ONE;
        PORT_AA: r.read_data = ID_AA;
        PORT_AB: r.read_data = ID_ONE;
        PORT_DATA: begin
          if (act_fn == FN_DISK) begin
            r.read_data = a.disk_byte;
            r.disk_read_req = 1'b1;
          end else if (act_fn == FN_CLOCK) begin
            r.read_data = clk_half ? a.clock_ms[7:0] : a.clock_ms[15:8];
            clk_half = ~clk_half;
          end else if (act_fn == FN_SSTAT) begin
            r.read_data = sstat;
          end
        end
        PORT_CTRL: begin
          r.read_data = stat;
          if (act_fn == FN_DISK || act_fn == FN_DISK2 || act_fn == FN_CLOCK) stat = ST_DONE;
        end
        default: r.bad_port = 1'b1;
      endcase
    end else begin
      case (a.port) inside
        PORT_02, PORT_2B, PORT_AB: ;
        PORT_DATA: begin
          if (act_fn == FN_DISK || act_fn == FN_DISK2 || act_fn == FN_FORMAT) begin
            p = phase;
            if (phase < PHASE_MAX) phase = phase + 4'd1;
            if (p == PHASE_UNIT) unit_b = a.write_data[0];
            else if (p == PHASE_TRACK) trk = a.write_data;
            else if (p == PHASE_SECT) sec = a.write_data;
            else if (act_fn == FN_FORMAT) begin
              if (p != PHASE_FMT0) r.format_req = 1'b1;
            end else if (p == PHASE_SEEK) begin
              base = int'(trk) * SectorsPerTrack * SectorBytes + int'(sec) * SectorBytes;
              if (base >= SectorBytes) begin
                r.seek_req = 1'b1;
                r.seek_pos = PosW'(base - SectorBytes);
              end
            end else if (p >= PHASE_MAX) begin
              r.disk_write_req = 1'b1;
              stat = ST_DONE;
            end
          end
        end
        PORT_CTRL: begin
          if ((~a.write_data) == pend_code) begin
            act_fn = pend_code;
            pend_code = CODE_IDLE;
            phase = PHASE_FIRST;
            case (act_fn) inside
              FN_DISK, FN_DISK2, FN_FORMAT, FN_CLOCK: begin
                stat = ST_READY;
                clk_half = 1'b1;
              end
              FN_SSTAT: begin
                stat = ST_READY;
                sstat = SS_BASE | (floppy_cfg ? SS_FLOPPY : 8'h00);
              end
              FN_BUSY: stat = ST_DONE;
              default: sstat = SS_BASE;
            endcase
          end else begin
            pend_code = a.write_data;
            stat = ST_PEND;
          end
        end
        default: r.bad_port = 1'b1;
      endcase
    end
    if (r.disk_read_req || r.disk_write_req || r.seek_req || r.format_req)
      r.unit_select = unit_b;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      err_count++;
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return 8'h00;
    if (r == 2) return 8'h01;
    if (r == 3) return 8'hff;
    return 8'($urandom);
  endfunction

  task automatic add_item(logic cmd, logic [7:0] port, logic [7:0] wd, logic [7:0] db,
                          logic [15:0] ck);
    item_t it;
    it.cmd = cmd;
    it.port = port;
    it.write_data = wd;
    it.disk_byte = db;
    it.clock_ms = ck;
    access_q.push_back(it);
    pushed_count++;
  endtask

  task automatic add_access(logic cmd, logic [7:0] port, logic [7:0] wd);
    add_item(cmd, port, wd, 8'($urandom), 16'($urandom));
  endtask

  task automatic add_noise();
    logic [7:0] ports[8];
    logic [7:0] port;
    ports = '{PORT_01, PORT_02, PORT_2A, PORT_2B, PORT_AA, PORT_AB, PORT_DATA, PORT_CTRL};
    if ($urandom_range(0, 1) == 0) port = ports[$urandom_range(0, 7)];
    else port = 8'($urandom);
    add_access(1'($urandom), port, 8'($urandom));
  endtask

  // A commit followed by a burst of data and control accesses, sometimes with a bad complement.
  task automatic add_session();
    logic [7:0] fn;
    int r;
    int wr_weight;
    r = $urandom_range(0, 7);
    case (r) inside
      0, 6: fn = FN_DISK;
      1: fn = FN_DISK2;
      2: fn = FN_SSTAT;
      3: fn = FN_BUSY;
      4: fn = FN_FORMAT;
      5: fn = FN_CLOCK;
      default: fn = 8'($urandom);
    endcase
    add_access(CMD_WRITE, PORT_CTRL, fn);
    if ($urandom_range(0, 9) == 0) add_access(CMD_WRITE, PORT_CTRL, 8'($urandom));
    else add_access(CMD_WRITE, PORT_CTRL, ~fn);
    if ($urandom_range(0, 3) != 0) add_access(CMD_READ, PORT_CTRL, 8'($urandom));
    wr_weight = (fn == FN_CLOCK || fn == FN_SSTAT) ? 2 : 7;
    repeat ($urandom_range(1, 14)) begin
      r = $urandom_range(0, 9);
      if (r < wr_weight) add_access(CMD_WRITE, PORT_DATA, pick_byte());
      else if (r < 9) add_access(CMD_READ, PORT_DATA, 8'($urandom));
      else add_access(CMD_READ, PORT_CTRL, 8'($urandom));
    end
  endtask

  task automatic run_random(int n);
    int target;
    target = pushed_count + n;
    while (pushed_count < target) begin
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 4)) add_noise();
      else add_session();
    end
  endtask

  task automatic wait_drained();
    while (accepted_count != pushed_count || port_result_q.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_floppy(logic v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    floppy_cfg = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10000000;
    $display("Some tests failed");
    $finish;
  end

  // Driver: presents queued accesses at the falling edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_fire) begin
    end else if (in_gap > 0) begin
      in_tvalid <= 1'b0;
      in_gap <= in_gap - 1;
    end else if (access_q.size() != 0) begin
      drv_item = access_q.pop_front();
      in_tvalid <= 1'b1;
      in_tuser <= drv_item.cmd;
      in_tdata <= {drv_item.clock_ms, drv_item.disk_byte, drv_item.write_data, drv_item.port};
      if (in_calm > 0) begin
        in_calm <= in_calm - 1;
        in_gap <= 0;
      end else begin
        in_gap <= pick_gap();
        if ($urandom_range(0, 49) == 0) in_calm <= $urandom_range(30, 100);
      end
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Receiver: random stalls, plus one long hold-off once traffic is under way.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (press_left > 0) begin
      out_tready <= 1'b0;
      press_left <= press_left - 1;
    end else if (!pressed && res_count >= 300) begin
      pressed <= 1'b1;
      press_left <= 150;
      out_tready <= 1'b0;
    end else if (out_stall > 0) begin
      out_tready <= 1'b0;
      out_stall <= out_stall - 1;
    end else begin
      out_tready <= 1'b1;
      if (out_calm > 0) begin
        out_calm <= out_calm - 1;
      end else begin
        out_stall <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
        if ($urandom_range(0, 49) == 0) out_calm <= $urandom_range(30, 100);
      end
    end
  end

  // Monitor: predicts each accepted access and checks each result transfer.
  always @(posedge clk) begin
    in_fire <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      seen_item.cmd = in_tuser[0];
      {seen_item.clock_ms, seen_item.disk_byte, seen_item.write_data, seen_item.port} = in_tdata;
      port_result_q.push_back(predict_access(seen_item));
      accepted_count <= accepted_count + 1;
    end
    if (rst_n && out_tvalid && out_tready) begin
      res_count <= res_count + 1;
      if (port_result_q.size() == 0) begin
        $display("%0t: unexpected result transfer, expected none, got %0h", $time, out_tdata);
        err_count++;
      end else begin
        want = port_result_q.pop_front();
        got = out_tdata[35:0];
        check_field("read_data", 32'(want.read_data), 32'(got.read_data));
        check_field("disk_read_req", 32'(want.disk_read_req), 32'(got.disk_read_req));
        check_field("disk_write_req", 32'(want.disk_write_req), 32'(got.disk_write_req));
        check_field("seek_req", 32'(want.seek_req), 32'(got.seek_req));
        check_field("seek_pos", 32'(want.seek_pos), 32'(got.seek_pos));
        check_field("format_req", 32'(want.format_req), 32'(got.format_req));
        check_field("unit_select", 32'(want.unit_select), 32'(got.unit_select));
        check_field("bad_port", 32'(want.bad_port), 32'(got.bad_port));
        check_field("pad", 32'h0, 32'(out_tdata[39:36]));
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    write_floppy(1'b0);

    add_access(CMD_READ, PORT_01, 8'hff);
    add_access(CMD_READ, PORT_02, 8'h00);
    add_access(CMD_READ, PORT_2A, 8'h00);
    add_access(CMD_READ, PORT_2B, 8'h00);
    add_access(CMD_READ, PORT_AA, 8'h00);
    add_access(CMD_READ, PORT_AB, 8'h00);
    add_access(CMD_READ, 8'h00, 8'h00);
    add_access(CMD_WRITE, 8'hff, 8'hff);
    add_access(CMD_WRITE, PORT_02, 8'h55);
    add_access(CMD_WRITE, PORT_2B, 8'haa);
    add_access(CMD_WRITE, PORT_AB, 8'hff);
    add_access(CMD_READ, PORT_CTRL, 8'h00);
    add_item(CMD_READ, PORT_DATA, 8'h00, 8'hff, 16'hffff);
    add_item(CMD_READ, PORT_DATA, 8'hff, 8'h00, 16'h0000);
    // Commit of the disk function, then a full setup at the largest track and sector.
    add_access(CMD_WRITE, PORT_CTRL, FN_DISK);
    add_access(CMD_WRITE, PORT_CTRL, ~FN_DISK);
    add_access(CMD_WRITE, PORT_DATA, 8'hff);
    add_access(CMD_WRITE, PORT_DATA, 8'hff);
    add_access(CMD_WRITE, PORT_DATA, 8'hff);
    repeat (3) add_access(CMD_WRITE, PORT_DATA, 8'h00);
    add_access(CMD_WRITE, PORT_DATA, 8'h00);
    add_access(CMD_WRITE, PORT_DATA, 8'h5a);
    add_access(CMD_READ, PORT_CTRL, 8'h00);
    wait_drained();

    write_floppy(1'b1);
    add_access(CMD_WRITE, PORT_CTRL, FN_SSTAT);
    add_access(CMD_WRITE, PORT_CTRL, ~FN_SSTAT);
    add_access(CMD_READ, PORT_DATA, 8'h00);
    run_random(400);
    wait_drained();

    write_floppy(1'b0);
    run_random(400);
    wait_drained();

    write_floppy(1'b1);
    run_random(400);
    wait_drained();
    repeat (10) @(negedge clk);

    if (err_count == 0 && port_result_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
